// File: design/transient_alert_ducker_defines.svh
// Assertion helpers shared by the design files.
`ifndef TRANSIENT_ALERT_DUCKER_DEFINES_SVH
`define TRANSIENT_ALERT_DUCKER_DEFINES_SVH

// Checked only out of reset.
`define TAD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tad assertion failed");

// Checked on every edge, reset included.
`define TAD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tad assertion failed");

`endif

// File: design/tad_pkg.sv
package tad_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               block_end;
    } t_in;

    typedef struct packed {
        logic [16:0] duck_gain;
        logic        alert_active;
    } t_out;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int CoefW    = 24;
    localparam int EnergyW  = 31;
    localparam int DuckW    = 17;
    localparam int HoldW    = 16;
    localparam int ThrW     = 12;
    localparam int MulAW    = 25;
    localparam int MulBW    = 32;
    localparam int ProdW    = MulAW + MulBW;
    localparam int StepW    = 4;

    localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SHORT_A   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LONG_A    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ATTACK    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RELEASE   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_HOLD      = 3'd6;

    localparam logic [ThrW-1:0]    THR_RESET   = 12'd1024;
    localparam logic [ThrW-1:0]    THR_MIN     = 12'd512;
    localparam logic [ThrW-1:0]    THR_MAX     = 12'd3072;
    localparam logic [CoefW-1:0]   SHORT_RESET = 24'd6987;
    localparam logic [CoefW-1:0]   LONG_A_RST  = 24'd175;
    localparam logic [CoefW-1:0]   ATK_RESET   = 24'd17467;
    localparam logic [CoefW-1:0]   REL_RESET   = 24'd699;
    localparam logic [HoldW-1:0]   HOLD_RESET  = 16'd9600;
    localparam logic [EnergyW-1:0] LONG_RESET  = 31'd1073742;
    localparam logic [EnergyW-1:0] BASE_FLOOR  = 31'd1074;
    localparam logic [DuckW-1:0]   UNITY_Q16   = 17'd65536;
    localparam logic [DuckW-1:0]   DUCK_LOW    = 17'd6554;

    typedef struct packed {
        logic             enable;
        logic [ThrW-1:0]  thr;        // already clamped
        logic [CoefW-1:0] short_alpha;
        logic [CoefW-1:0] long_alpha;
        logic [CoefW-1:0] atk_coeff;
        logic [CoefW-1:0] rel_coeff;
        logic [HoldW-1:0] hold_len;
    } t_cfg;

    // multiplier operand selects
    localparam logic [2:0] A_NONE   = 3'd0;
    localparam logic [2:0] A_SAMPLE = 3'd1;
    localparam logic [2:0] A_SALPHA = 3'd2;
    localparam logic [2:0] A_LALPHA = 3'd3;
    localparam logic [2:0] A_THR    = 3'd4;
    localparam logic [2:0] A_COEF   = 3'd5;

    localparam logic [2:0] B_NONE   = 3'd0;
    localparam logic [2:0] B_SAMPLE = 3'd1;
    localparam logic [2:0] B_PSHORT = 3'd2;
    localparam logic [2:0] B_ELONG  = 3'd3;
    localparam logic [2:0] B_BASE   = 3'd4;
    localparam logic [2:0] B_DUCK   = 3'd5;

    // write-back targets
    localparam logic [2:0] WB_NONE  = 3'd0;
    localparam logic [2:0] WB_SHORT = 3'd1;
    localparam logic [2:0] WB_LONG  = 3'd2;
    localparam logic [2:0] WB_ALERT = 3'd3;
    localparam logic [2:0] WB_DUCK  = 3'd4;

    // sequencing
    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

    localparam logic [StepW-1:0] STEP_IDLE   = 4'd0;
    localparam logic [StepW-1:0] STEP_SQUARE = 4'd1;
    localparam logic [StepW-1:0] STEP_SHORT  = 4'd2;
    localparam logic [StepW-1:0] STEP_LONG   = 4'd3;
    localparam logic [StepW-1:0] STEP_LWB    = 4'd4;
    localparam logic [StepW-1:0] STEP_THR    = 4'd5;
    localparam logic [StepW-1:0] STEP_ALERT  = 4'd6;
    localparam logic [StepW-1:0] STEP_DMUL   = 4'd7;
    localparam logic [StepW-1:0] STEP_DUCK   = 4'd8;

    typedef struct packed {
        logic [2:0]       a_sel;
        logic [2:0]       b_sel;
        logic             mul_en;
        logic             ld_e;
        logic [2:0]       wb;
        logic             emit;
        logic [1:0]       jmp;
        logic [StepW-1:0] tgt;
    } t_uword;

    typedef struct packed {
        t_uword w;
        logic   adv;
    } t_ctl;

    function automatic t_uword ucode(input logic [StepW-1:0] step);
        t_uword w;
        w = '{a_sel: A_NONE, b_sel: B_NONE, mul_en: 1'b0, ld_e: 1'b0, wb: WB_NONE,
              emit: 1'b0, jmp: JMP_NEXT, tgt: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.jmp = JMP_WAIT_IN;
                w.tgt = STEP_DUCK;
            end
            STEP_SQUARE: begin
                w.a_sel = A_SAMPLE; w.b_sel = B_SAMPLE; w.mul_en = 1'b1;
            end
            STEP_SHORT: begin
                w.a_sel = A_SALPHA; w.b_sel = B_PSHORT; w.mul_en = 1'b1; w.ld_e = 1'b1;
            end
            STEP_LONG: begin
                w.a_sel = A_LALPHA; w.b_sel = B_ELONG; w.mul_en = 1'b1; w.wb = WB_SHORT;
            end
            STEP_LWB: begin
                w.wb = WB_LONG;
            end
            STEP_THR: begin
                w.a_sel = A_THR; w.b_sel = B_BASE; w.mul_en = 1'b1;
            end
            STEP_ALERT: begin
                w.wb = WB_ALERT;
            end
            STEP_DMUL: begin
                w.a_sel = A_COEF; w.b_sel = B_DUCK; w.mul_en = 1'b1;
            end
            STEP_DUCK: begin
                w.wb = WB_DUCK; w.emit = 1'b1; w.jmp = JMP_WAIT_OUT; w.tgt = STEP_IDLE;
            end
            default: begin
                w.jmp = JMP_WAIT_OUT;
                w.tgt = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/tad_cfg.sv
module tad_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tad_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tad_pkg::CfgDataW-1:0] i_cfg_data,
    output tad_pkg::t_cfg                o_cfg
);

    logic                          r_enable;
    logic [tad_pkg::ThrW-1:0]      r_thr;
    logic [tad_pkg::CoefW-1:0]     r_short_a;
    logic [tad_pkg::CoefW-1:0]     r_long_a;
    logic [tad_pkg::CoefW-1:0]     r_atk;
    logic [tad_pkg::CoefW-1:0]     r_rel;
    logic [tad_pkg::HoldW-1:0]     r_hold;
    logic [tad_pkg::ThrW-1:0]      w_thr_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_thr     <= tad_pkg::THR_RESET;
            r_short_a <= tad_pkg::SHORT_RESET;
            r_long_a  <= tad_pkg::LONG_A_RST;
            r_atk     <= tad_pkg::ATK_RESET;
            r_rel     <= tad_pkg::REL_RESET;
            r_hold    <= tad_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tad_pkg::REG_ENABLE:    r_enable  <= i_cfg_data[0];
                tad_pkg::REG_THRESHOLD: r_thr     <= i_cfg_data[tad_pkg::ThrW-1:0];
                tad_pkg::REG_SHORT_A:   r_short_a <= i_cfg_data;
                tad_pkg::REG_LONG_A:    r_long_a  <= i_cfg_data;
                tad_pkg::REG_ATTACK:    r_atk     <= i_cfg_data;
                tad_pkg::REG_RELEASE:   r_rel     <= i_cfg_data;
                tad_pkg::REG_HOLD:      r_hold    <= i_cfg_data[tad_pkg::HoldW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_thr < tad_pkg::THR_MIN) begin
            w_thr_clamp = tad_pkg::THR_MIN;
        end else if (r_thr > tad_pkg::THR_MAX) begin
            w_thr_clamp = tad_pkg::THR_MAX;
        end else begin
            w_thr_clamp = r_thr;
        end
    end

    assign o_cfg = '{enable: r_enable, thr: w_thr_clamp, short_alpha: r_short_a,
                     long_alpha: r_long_a, atk_coeff: r_atk, rel_coeff: r_rel,
                     hold_len: r_hold};

endmodule

// File: design/tad_seq.sv
`include "transient_alert_ducker_defines.svh"

module tad_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_enable,
    input  logic          i_out_stall,
    output logic          o_in_ready,
    output tad_pkg::t_ctl o_ctl
);

    logic [tad_pkg::StepW-1:0] r_step;
    logic [tad_pkg::StepW-1:0] n_step;
    tad_pkg::t_uword           w_word;
    logic                      w_adv;

    assign w_word = tad_pkg::ucode(r_step);

    always_comb begin
        w_adv  = 1'b1;
        n_step = r_step + 1'b1;
        case (w_word.jmp)
            tad_pkg::JMP_NEXT: ;
            tad_pkg::JMP_WAIT_IN: begin
                w_adv = i_in_valid;
                // disabled: skip the math, go straight to the result step
                if (!i_enable) begin
                    n_step = w_word.tgt;
                end
            end
            tad_pkg::JMP_WAIT_OUT: begin
                w_adv  = !i_out_stall;
                n_step = w_word.tgt;
            end
            default: n_step = tad_pkg::STEP_IDLE;
        endcase
        if (!w_adv) begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tad_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready = (w_word.jmp == tad_pkg::JMP_WAIT_IN);
    assign o_ctl      = '{w: w_word, adv: w_adv};

    `TAD_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_step == tad_pkg::STEP_IDLE)
    `TAD_ASSERT(a_start, (o_in_ready && i_in_valid && i_enable) |=> r_step == tad_pkg::STEP_SQUARE)
    `TAD_ASSERT(a_bypass, (o_in_ready && i_in_valid && !i_enable) |=> r_step == tad_pkg::STEP_DUCK)

endmodule

// File: design/tad_dp.sv
`include "transient_alert_ducker_defines.svh"

module tad_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tad_pkg::t_ctl i_ctl,
    input  tad_pkg::t_cfg i_cfg,
    input  logic          i_in_fire,
    input  tad_pkg::t_in  i_in_data,
    input  logic          i_out_ready,
    output logic          o_out_stall,
    output logic          o_out_valid,
    output tad_pkg::t_out o_out_data
);

    localparam int EW = tad_pkg::EnergyW;
    localparam int DW = tad_pkg::DuckW;
    localparam int SH = 24;              // Q0.24 coefficient scale
    localparam int SW = tad_pkg::ProdW - SH;

    logic signed [15:0]                r_sample;
    logic                              r_last;
    logic                              r_byp;
    logic signed [tad_pkg::ProdW-1:0]  r_prod;
    logic [EW-1:0]                     r_energy;
    logic [EW-1:0]                     r_short;
    logic [EW-1:0]                     r_long;
    logic [DW-1:0]                     r_lvl;
    logic [DW-1:0]                     r_goal;
    logic [tad_pkg::HoldW-1:0]         r_hold;
    logic                              r_alert;
    logic                              r_out_valid;
    tad_pkg::t_out                     r_out;

    logic signed [tad_pkg::MulAW-1:0]  w_a;
    logic signed [tad_pkg::MulBW-1:0]  w_b;
    logic signed [tad_pkg::ProdW-1:0]  w_prod;
    logic signed [SW-1:0]              w_step;
    logic signed [SW:0]                w_short_sum;
    logic signed [SW:0]                w_long_sum;
    logic signed [SW:0]                w_lvl_sum;
    logic [DW-1:0]                     w_lvl_next;
    logic [EW-1:0]                     w_base;
    logic [DW:0]                       w_ddiff;
    logic [tad_pkg::CoefW-1:0]         w_coef;
    logic                              w_hit;
    logic                              w_emit;

    assign w_base = (r_long > tad_pkg::BASE_FLOOR) ? r_long : tad_pkg::BASE_FLOOR;
    assign w_coef = (r_lvl > r_goal) ? i_cfg.atk_coeff : i_cfg.rel_coeff;
    assign w_ddiff = {1'b0, r_goal} - {1'b0, r_lvl};

    always_comb begin
        case (i_ctl.w.a_sel)
            tad_pkg::A_SAMPLE: w_a = {{(tad_pkg::MulAW-16){r_sample[15]}}, r_sample};
            tad_pkg::A_SALPHA: w_a = {1'b0, i_cfg.short_alpha};
            tad_pkg::A_LALPHA: w_a = {1'b0, i_cfg.long_alpha};
            tad_pkg::A_THR:    w_a = {{(tad_pkg::MulAW-tad_pkg::ThrW){1'b0}}, i_cfg.thr};
            tad_pkg::A_COEF:   w_a = {1'b0, w_coef};
            default:           w_a = '0;
        endcase
        case (i_ctl.w.b_sel)
            tad_pkg::B_SAMPLE: w_b = {{(tad_pkg::MulBW-16){r_sample[15]}}, r_sample};
            // product register still holds the square here
            tad_pkg::B_PSHORT: w_b = {1'b0, r_prod[EW-1:0]} - {1'b0, r_short};
            tad_pkg::B_ELONG:  w_b = {1'b0, r_energy} - {1'b0, r_long};
            tad_pkg::B_BASE:   w_b = {1'b0, w_base};
            tad_pkg::B_DUCK:   w_b = {{(tad_pkg::MulBW-DW-1){w_ddiff[DW]}}, w_ddiff};
            default:           w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;

    // floor(coef * diff / 2^24)
    assign w_step      = r_prod[tad_pkg::ProdW-1:SH];
    assign w_short_sum = $signed({{(SW+1-EW){1'b0}}, r_short}) + $signed({w_step[SW-1], w_step});
    assign w_long_sum  = $signed({{(SW+1-EW){1'b0}}, r_long}) + $signed({w_step[SW-1], w_step});
    assign w_lvl_sum   = $signed({{(SW+1-DW){1'b0}}, r_lvl}) + $signed({w_step[SW-1], w_step});

    always_comb begin
        if (w_lvl_sum[SW]) begin
            w_lvl_next = '0;
        end else if (w_lvl_sum > $signed({{(SW+1-DW){1'b0}}, tad_pkg::UNITY_Q16})) begin
            w_lvl_next = tad_pkg::UNITY_Q16;
        end else begin
            w_lvl_next = w_lvl_sum[DW-1:0];
        end
    end

    // short*256 > thr*baseline
    assign w_hit = {4'b0, r_short, 8'b0} > r_prod[EW+tad_pkg::ThrW-1:0];

    assign w_emit = i_ctl.adv && i_ctl.w.emit && r_last;

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_sample <= i_in_data.sample;
            r_last   <= i_in_data.block_end;
            r_byp    <= !i_cfg.enable;
        end
        if (i_ctl.adv && i_ctl.w.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.adv && i_ctl.w.ld_e) begin
            r_energy <= r_prod[EW-1:0];
        end
        if (w_emit) begin
            r_out.duck_gain    <= r_byp ? tad_pkg::UNITY_Q16 : w_lvl_next;
            r_out.alert_active <= r_byp ? 1'b0 : r_alert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short     <= '0;
            r_long      <= tad_pkg::LONG_RESET;
            r_lvl       <= tad_pkg::UNITY_Q16;
            r_goal      <= tad_pkg::UNITY_Q16;
            r_hold      <= '0;
            r_alert     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.adv) begin
                case (i_ctl.w.wb)
                    tad_pkg::WB_SHORT: r_short <= w_short_sum[EW-1:0];
                    tad_pkg::WB_LONG:  r_long  <= w_long_sum[EW-1:0];
                    tad_pkg::WB_ALERT: begin
                        if (w_hit) begin
                            r_goal  <= tad_pkg::DUCK_LOW;
                            r_hold  <= i_cfg.hold_len;
                            r_alert <= 1'b1;
                        end else if (r_hold != '0) begin
                            r_hold <= r_hold - 1'b1;
                        end else begin
                            r_goal  <= tad_pkg::UNITY_Q16;
                            r_alert <= 1'b0;
                        end
                    end
                    tad_pkg::WB_DUCK: begin
                        if (!r_byp) begin
                            r_lvl <= w_lvl_next;
                        end
                    end
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_stall = r_last && r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TAD_ASSERT(a_lvl_range, r_lvl <= tad_pkg::UNITY_Q16)
    `TAD_ASSERT(a_goal_vals, r_goal == tad_pkg::UNITY_Q16 || r_goal == tad_pkg::DUCK_LOW)
    `TAD_ASSERT(a_alert_goal, r_alert == 1'b0 |-> r_goal == tad_pkg::UNITY_Q16)

endmodule

// File: design/transient_alert_ducker.sv
// Transient alert ducker: takes one signed Q1.15 sample per input transaction and,
// on samples flagged block_end, returns the Q1.16 duck gain and the alert flag.
// Each sample runs an accept step plus eight microcode steps that time-share a
// single 25x32 multiplier (square, two trackers, threshold, duck level). With
// enable low a sample skips from accept to the duck step. The next sample is
// accepted while a result still waits in the output register; a block-end sample
// holds on its last step only if that register is still occupied. Configuration
// writes take effect at once and must only be issued while the block is idle.
module transient_alert_ducker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tad_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tad_pkg::t_out                o_out_data,
    input  logic                         i_cfg_we,
    input  logic [tad_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tad_pkg::CfgDataW-1:0] i_cfg_data
);

    tad_pkg::t_cfg w_cfg;
    tad_pkg::t_ctl w_ctl;
    logic          w_in_ready;
    logic          w_out_stall;

    tad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tad_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_enable    (w_cfg.enable),
        .i_out_stall (w_out_stall),
        .o_in_ready  (w_in_ready),
        .o_ctl       (w_ctl)
    );

    tad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cfg       (w_cfg),
        .i_in_fire   (i_in_valid && w_in_ready),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_stall (w_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = w_in_ready;

endmodule
